[rtl/pixel_binning_saturating_core_macros.svh]
// assertion macros shared by the rtl files
`ifndef PIXEL_BINNING_SATURATING_CORE_MACROS_SVH
`define PIXEL_BINNING_SATURATING_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PBS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbs assertion failed");
// next-cycle implication
`define PBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbs assertion failed");
`else
`define PBS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define PBS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/pbs_pkg.sv]
`timescale 1ns / 1ps
package pbs_pkg;

   localparam int PIX_W      = 16;
   localparam int IMG_W_W    = 13;
   localparam int SHIFT_W    = 2;
   localparam int RIG_W      = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHIFT_X     = 2'd0,
      CSR_SHIFT_Y     = 2'd1,
      CSR_IMAGE_WIDTH = 2'd2
   } csr_index_type;

   localparam logic [SHIFT_W-1:0] MAX_SHIFT_X = 2'd2;
   localparam logic [IMG_W_W-1:0] WIDTH_RESET = 13'd4096;

   // control carried along with a finished row partial
   typedef struct packed {
      logic emit;    // last row of the group: goes out
      logic merge;   // add the line store entry
      logic eol;     // last bin of the output row
   } bin_ctl_type;

   function automatic pixel_type sat_add(pixel_type a, pixel_type b);
      logic [PIX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[PIX_W] ? '1 : s[PIX_W-1:0];
   endfunction

endpackage

[rtl/pbs_req_if.sv]
`timescale 1ns / 1ps
interface pbs_req_if
   import pbs_pkg::*;
   ();
   logic      valid;
   logic      ready;
   pixel_type pixel_value;
   logic      start_of_frame;

   modport source (output valid, output pixel_value, output start_of_frame, input ready);
   modport sink (input valid, input pixel_value, input start_of_frame, output ready);
endinterface

[rtl/pbs_rsp_if.sv]
`timescale 1ns / 1ps
interface pbs_rsp_if
   import pbs_pkg::*;
   ();
   logic      valid;
   logic      ready;
   pixel_type binned_value;
   logic      end_of_line;

   modport source (output valid, output binned_value, output end_of_line, input ready);
   modport sink (input valid, input binned_value, input end_of_line, output ready);
endinterface

[rtl/pixel_binning_saturating_core.sv]
// pixel binning core: sums 2^shift_x by 2^shift_y pixel blocks, saturated at 65535
// a bin's last pixel goes into the second stage register, then the result register
// throughput: one pixel per cycle unless stalled, set by the single line store RMW
// reset: synchronous, active high; counters, partial and config return to defaults
// the line store is not cleared; entries are written on all but a group's last row
`timescale 1ns / 1ps
`include "pixel_binning_saturating_core_macros.svh"
module pixel_binning_saturating_core
   import pbs_pkg::*;
#(
   parameter int MAX_WIDTH   = 4096,
   parameter int MAX_SHIFT_Y = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   pbs_req_if.sink               req_if,
   pbs_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CCW  = $clog2(MAX_WIDTH);
   localparam int CMPW = ((CCW > IMG_W_W) ? CCW : IMG_W_W) + 1;

   // configuration registers
   logic [SHIFT_W-1:0] shift_x_ff;
   logic [SHIFT_W-1:0] shift_y_ff;
   logic [IMG_W_W-1:0] image_width_ff;

   // position and row accumulator
   logic [CCW-1:0]   cc_ff, cc_in;
   logic [RIG_W-1:0] rig_ff, rig_in;
   pixel_type        rp_ff, rp_in;

   // second stage: finished row partial of one bin
   logic             s1_valid_ff;
   bin_ctl_type      s1_ctl_ff, s1_ctl_in;
   pixel_type        s1_partial_ff;
   logic [CCW-1:0]   s1_addr_ff;

   // result register
   logic             rsp_valid_ff;
   pixel_type        rsp_value_ff;
   logic             rsp_eol_ff;

   // effective settings
   logic [SHIFT_W-1:0] sx, sy;
   logic [IMG_W_W-1:0] w_eff, nb, used;
   logic [CCW-1:0]     xmask;
   logic [RIG_W:0]     by;

   // first stage decode
   logic [CCW-1:0]   cc_cur, px, bin;
   logic [RIG_W-1:0] rig_cur;
   pixel_type        rp_cur, rp_new;
   logic             in_used, last_px, grp_last, wrap;
   logic [RIG_W:0]   rig_inc;
   logic [CMPW-1:0]  cc_inc;

   logic      acc, out_free, s1_adv;
   logic      ls_rd_en, ls_wr_en;
   pixel_type ls_rd_data, bin_value;

   // ---------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_x_ff     <= '0;
         shift_y_ff     <= '0;
         image_width_ff <= WIDTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SHIFT_X:     shift_x_ff     <= csr_wdata[SHIFT_W-1:0];
            CSR_SHIFT_Y:     shift_y_ff     <= csr_wdata[SHIFT_W-1:0];
            CSR_IMAGE_WIDTH: image_width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // clamp the settings into range
   // ---------------------------------------------------------------
   always_comb begin
      // horizontal factor tops out at four
      sx = (shift_x_ff > MAX_SHIFT_X) ? MAX_SHIFT_X : shift_x_ff;
      sy = (32'(shift_y_ff) > MAX_SHIFT_Y) ? SHIFT_W'(MAX_SHIFT_Y) : shift_y_ff;
      // zero width acts as one, wider than the line store acts as its depth
      if (image_width_ff == '0) begin
         w_eff = IMG_W_W'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_eff = IMG_W_W'(MAX_WIDTH);
      end else begin
         w_eff = image_width_ff;
      end
      nb    = w_eff >> sx;
      used  = nb << sx;
      xmask = ~({CCW{1'b1}} << sx);
      by    = (RIG_W + 1)'(1) << sy;
   end

   // ---------------------------------------------------------------
   // first stage: horizontal accumulate and counter update
   // ---------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign s1_adv   = s1_valid_ff && (!s1_ctl_ff.emit || out_free);
   assign req_if.ready = !s1_valid_ff || s1_adv;
   assign acc = req_if.valid && req_if.ready;

   always_comb begin
      // start of frame clears position and partial before the pixel is used
      cc_cur  = req_if.start_of_frame ? '0 : cc_ff;
      rig_cur = req_if.start_of_frame ? '0 : rig_ff;
      rp_cur  = req_if.start_of_frame ? '0 : rp_ff;

      px  = cc_cur & xmask;
      bin = cc_cur >> sx;

      // trailing pixels past the last whole bin are dropped
      in_used  = CMPW'(cc_cur) < CMPW'(used);
      last_px  = in_used && (px == xmask);
      rig_inc  = {1'b0, rig_cur} + (RIG_W + 1)'(1);
      // a row past the group counts as the group's last row
      grp_last = rig_inc >= by;
      rp_new   = sat_add((px == '0) ? '0 : rp_cur, req_if.pixel_value);

      cc_inc = CMPW'(cc_cur) + CMPW'(1);
      wrap   = cc_inc >= CMPW'(w_eff);

      cc_in  = wrap ? '0 : cc_inc[CCW-1:0];
      rig_in = wrap ? (grp_last ? '0 : rig_inc[RIG_W-1:0]) : rig_cur;
      rp_in  = in_used ? rp_new : rp_cur;

      s1_ctl_in.emit  = grp_last;
      s1_ctl_in.merge = rig_cur != '0;
      s1_ctl_in.eol   = (CMPW'(bin) + CMPW'(1)) == CMPW'(nb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff       <= '0;
         rig_ff      <= '0;
         rp_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else if (acc) begin
         cc_ff       <= cc_in;
         rig_ff      <= rig_in;
         rp_ff       <= rp_in;
         s1_valid_ff <= last_px;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_ctl_ff     <= s1_ctl_in;
         s1_partial_ff <= rp_new;
         s1_addr_ff    <= bin;
      end
   end

   // ---------------------------------------------------------------
   // line store: column partials across the rows of a group
   // ---------------------------------------------------------------
   // read issued with the bin's last pixel, data back for the second stage
   assign ls_rd_en = acc && last_px && (rig_cur != '0);
   // only non-final rows store, and those never stall
   assign ls_wr_en = s1_valid_ff && !s1_ctl_ff.emit;

   pbs_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CCW)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (ls_rd_en),
      .rd_addr (bin),
      .rd_data (ls_rd_data),
      .wr_en   (ls_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (bin_value)
   );

   // second stage: merge with the stored column sum
   assign bin_value = s1_ctl_ff.merge ? sat_add(ls_rd_data, s1_partial_ff) : s1_partial_ff;

   // ---------------------------------------------------------------
   // result register: lets the next beat in while a result waits
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && s1_ctl_ff.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_ctl_ff.emit) begin
         rsp_value_ff <= bin_value;
         rsp_eol_ff   <= s1_ctl_ff.eol;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.binned_value = rsp_value_ff;
   assign rsp_if.end_of_line  = rsp_eol_ff;

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   `PBS_ASSERT_IMPL(a_stall_blocks_req, clock, reset, s1_valid_ff && s1_ctl_ff.emit && rsp_valid_ff && !rsp_if.ready, !req_if.ready)
   `PBS_ASSERT_NEXT(a_emit_lands, clock, reset, s1_valid_ff && s1_ctl_ff.emit && out_free, rsp_valid_ff)
   `PBS_ASSERT_NEXT(a_no_bin_no_stage, clock, reset, acc && !last_px, !s1_valid_ff)
   `PBS_ASSERT_NEXT(a_merge_has_read, clock, reset, ls_rd_en, s1_valid_ff && s1_ctl_ff.merge)

endmodule

[rtl/pbs_line_store.sv]
`timescale 1ns / 1ps
`include "pixel_binning_saturating_core_macros.svh"
module pbs_line_store
   import pbs_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output pixel_type     rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  pixel_type     wr_data
);

   pixel_type mem [DEPTH];
   pixel_type q_ff;
   pixel_type fwd_ff;
   logic      hit_ff;
   logic      hit_in;

   // read and write to the same entry in one cycle: take the new data
   assign hit_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff   <= mem[rd_addr];
         fwd_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= hit_in;
      end
   end

   assign rd_data = hit_ff ? fwd_ff : q_ff;

   `PBS_ASSERT_NEXT(a_fwd_capture, clock, reset, rd_en && hit_in, hit_ff && rd_data == $past(wr_data))

endmodule

[dv/tb_pixel_binning_saturating_core.sv]
`timescale 1ns / 1ps
module tb_pixel_binning_saturating_core;
   import pbs_pkg::*;

   localparam int LINE_DEPTH     = 4096;   // line store depth at the default MAX_WIDTH
   localparam int LATENCY_PAD    = 6;      // pad that covers the pipe latency, with margin
   localparam int DRAIN_LIMIT    = 1000;   // cycles to wait for pending bins to show up
   localparam int WATCHDOG_LIMIT = 2000;   // cycles with no beat on either side
   localparam int RANDOM_ITEMS   = 660;
   localparam int CALM_FROM      = 540;    // random pixels after which idling stops
   localparam int WIDE_ITEMS     = 48;     // pixels sent at the widest setting
   localparam int REPORT_CAP     = 40;

   // one binned output beat as the block should deliver it
   typedef struct {
      pixel_type value;
      logic      eol;
   } binned_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pbs_req_if req_bus ();
   pbs_rsp_if rsp_bus ();

   pixel_binning_saturating_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block: configuration and binning state
   logic [SHIFT_W-1:0]  cfg_shift_x;
   logic [SHIFT_W-1:0]  cfg_shift_y;
   logic [IMG_W_W-1:0]  cfg_width;
   pixel_type           line_store [LINE_DEPTH];
   pixel_type           row_acc;
   int unsigned         col_pos;
   int unsigned         group_row;

   // binned beats still owed by the block, oldest first
   binned_beat_type     binned_expect [$];

   int unsigned pixels_sent;
   int unsigned bins_checked;
   int unsigned csr_writes;
   int unsigned mismatch_count;
   int unsigned quiet_cycles;

   // idling knobs, in percent of starting a burst: per pixel for gaps, per cycle for stalls
   int unsigned gap_pct;
   int unsigned stall_pct;
   int unsigned stall_left;

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // exact sum of nonnegative terms clipped to the pixel range
   function automatic pixel_type clip_sum(int unsigned a, int unsigned b);
      int unsigned s;
      s = a + b;
      return (s > 32'd65535) ? 16'hFFFF : pixel_type'(s);
   endfunction

   // advance the shadow by one accepted pixel, queue the bin it completes
   function automatic void predict_pixel(pixel_type pix, logic sof);
      int unsigned     sx, sy, w, bx, by, nb, used, bin_idx, phase;
      pixel_type       bin_sum;
      binned_beat_type beat;
      // shift_x of 3 clamps to a factor of 4; shift_y cannot pass 3 in two bits
      sx = (cfg_shift_x > MAX_SHIFT_X) ? MAX_SHIFT_X : cfg_shift_x;
      sy = cfg_shift_y;
      // width 0 runs as 1, anything past the line store runs as its depth
      w = cfg_width;
      if (w == 0) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      bx   = 1 << sx;
      by   = 1 << sy;
      nb   = w >> sx;
      used = nb << sx;

      if (sof) begin
         col_pos   = 0;
         group_row = 0;
         row_acc   = '0;
      end

      // columns past the last whole bin are dropped
      if (col_pos < used) begin
         bin_idx = (col_pos >> sx) % LINE_DEPTH;
         phase   = col_pos & (bx - 1);
         row_acc = clip_sum((phase == 0) ? 0 : row_acc, pix);
         if (phase == bx - 1) begin
            bin_sum = row_acc;
            if (group_row != 0) bin_sum = clip_sum(line_store[bin_idx], bin_sum);
            // a row count past the group end also counts as the last row
            if (group_row + 1 >= by) begin
               beat.value = bin_sum;
               beat.eol   = (bin_idx + 1 == nb);
               binned_expect.push_back(beat);
            end else begin
               line_store[bin_idx] = bin_sum;
            end
         end
      end

      // a column past the width (width cut mid-row) ends the row here
      col_pos++;
      if (col_pos >= w) begin
         col_pos   = 0;
         group_row = (group_row + 1 >= by) ? 0 : group_row + 1;
      end
      col_pos   = col_pos & 32'hFFF;
      group_row = group_row & 32'h7;
   endfunction

   // ------------------------------------------------------------------
   // mismatch reporting and result checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("mismatch @%0t: %s", $time, what);
   endtask

   // every accepted output beat is matched against the oldest pending bin
   always @(posedge clock) begin : check_bins
      binned_beat_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (binned_expect.size() == 0) begin
            report_mismatch($sformatf("binned beat %h eol %b with nothing pending",
                                      rsp_bus.binned_value, rsp_bus.end_of_line));
         end else begin
            want = binned_expect.pop_front();
            if (rsp_bus.binned_value !== want.value)
               report_mismatch($sformatf("binned_value %h, wanted %h",
                                         rsp_bus.binned_value, want.value));
            if (rsp_bus.end_of_line !== want.eol)
               report_mismatch($sformatf("end_of_line %b, wanted %b (value %h)",
                                         rsp_bus.end_of_line, want.eol, want.value));
            bins_checked++;
         end
      end
   end

   // watchdog: a long stretch with no beat on either channel means a hang
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles with no beat, %0d bins pending",
                  quiet_cycles, binned_expect.size());
         $display("FAIL pixel_binning_saturating_core");
         $finish;
      end
   end

   // output side back-pressure: random stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------

   // one pixel beat; an optional idle burst goes ahead of it
   task automatic send_pixel(pixel_type pix, logic sof);
      int unsigned gap;
      @(negedge clock);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 17);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.pixel_value    <= pix;
      req_bus.start_of_frame <= sof;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_pixel(pix, sof);
      pixels_sent++;
   endtask

   // register write; the shadow copy follows the same field widths
   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SHIFT_X:     cfg_shift_x = data[SHIFT_W-1:0];
         CSR_SHIFT_Y:     cfg_shift_y = data[SHIFT_W-1:0];
         CSR_IMAGE_WIDTH: cfg_width   = data[IMG_W_W-1:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // stop sending, let pending bins arrive, then cover the pipe latency;
   // anything still pending after the drain limit is a failure
   task automatic settle_block();
      int unsigned waited;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      waited = 0;
      while (binned_expect.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY_PAD) @(posedge clock);
      if (binned_expect.size() != 0) begin
         report_mismatch($sformatf("%0d binned beats never arrived, first %h",
                                   binned_expect.size(), binned_expect[0].value));
         binned_expect.delete();
      end
   endtask

   // full binning setup from an idle block
   task automatic set_binning(logic [1:0] sx, logic [1:0] sy, logic [12:0] width);
      settle_block();
      write_csr(CSR_SHIFT_X, CSR_DATA_W'(sx));
      write_csr(CSR_SHIFT_Y, CSR_DATA_W'(sy));
      write_csr(CSR_IMAGE_WIDTH, width);
   endtask

   // pixel mix weighted toward the saturation corner
   function automatic pixel_type random_pixel();
      case ($urandom_range(0, 7))
         0:       return 16'hFFFF;
         1:       return 16'h0000;
         2:       return pixel_type'($urandom_range(16'hF000, 16'hFFFF));
         default: return pixel_type'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // out of reset: 1x1 binning over a 4096 wide row, so each pixel passes through
   task automatic test_reset_defaults();
      send_pixel(16'h0000, 1'b1);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'h5555, 1'b0);
      send_pixel(16'hAAAA, 1'b0);
   endtask

   // 2x2 bin whose row partial already clips, then a zero row on top
   task automatic test_saturation();
      set_binning(2'd1, 2'd1, 13'd2);
      send_pixel(16'hFFFF, 1'b1);
      send_pixel(16'h0001, 1'b0);
      send_pixel(16'h0000, 1'b0);
      send_pixel(16'h0000, 1'b0);
   endtask

   // shift_x of 3 runs as 4 wide with a trailing partial bin,
   // then width 0 runs as a one pixel row
   task automatic test_range_clamps();
      int k;
      set_binning(2'd3, 2'd0, 13'd9);
      for (k = 0; k < 9; k++) send_pixel(16'h1111 << (k % 4), k == 0);
      set_binning(2'd0, 2'd0, 13'd0);
      send_pixel(16'h8001, 1'b1);
      send_pixel(16'h7FFE, 1'b0);
   endtask

   // width lowered mid-row: the next pixel is trailing and closes the row
   task automatic test_width_cut();
      int k;
      set_binning(2'd0, 2'd0, 13'd16);
      for (k = 0; k < 4; k++) send_pixel(random_pixel(), k == 0);
      settle_block();
      write_csr(CSR_IMAGE_WIDTH, 13'd3);
      for (k = 0; k < 4; k++) send_pixel(random_pixel(), 1'b0);
   endtask

   // shift_y lowered mid-group: the row past the new group end still emits
   task automatic test_group_cut();
      int k;
      set_binning(2'd0, 2'd2, 13'd2);
      for (k = 0; k < 4; k++) send_pixel(random_pixel(), k == 0);
      settle_block();
      write_csr(CSR_SHIFT_Y, 13'd1);
      for (k = 0; k < 2; k++) send_pixel(random_pixel(), 1'b0);
   endtask

   // widest setting: width 8191 runs as 4096, the row head passes straight
   // through with end_of_line low
   task automatic test_wide_rows();
      int k;
      set_binning(2'd0, 2'd0, 13'd8191);
      for (k = 0; k < WIDE_ITEMS; k++) send_pixel(random_pixel(), k == 0);
   endtask

   // random frames: mostly whole row groups with random content, plus
   // stray frame starts and trailing partial rows as noise
   task automatic test_random_frames();
      int unsigned random_sent, w_eff, by, rows, count, k;
      logic [1:0]  sx, sy;
      logic [12:0] width;
      bit          fresh, first_phase;
      random_sent = 0;
      first_phase = 1'b1;
      sx = '0;
      sy = '0;
      width = '0;
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent >= CALM_FROM) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       gap_pct = 0;
               1:       gap_pct = 8;
               default: gap_pct = 25;
            endcase
            case ($urandom_range(0, 2))
               0:       stall_pct = 0;
               1:       stall_pct = 8;
               default: stall_pct = 25;
            endcase
         end
         // a new setting always starts a fresh frame so the line store is
         // written on the first row before any later row reads it
         fresh = first_phase || ($urandom_range(0, 3) != 0);
         first_phase = 1'b0;
         if (fresh) begin
            sx = 2'($urandom_range(0, 3));
            sy = 2'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
               0:       width = 13'd0;
               1:       width = 13'($urandom_range(25, 160));
               default: width = 13'($urandom_range(1, 24));
            endcase
            set_binning(sx, sy, width);
         end
         w_eff = (width == 0) ? 1 : width;
         by    = 1 << sy;
         rows  = by * $urandom_range(1, 2) + $urandom_range(0, 1);
         count = rows * w_eff + $urandom_range(0, w_eff - 1);
         if (count > 320) count = 320;
         if (count > RANDOM_ITEMS - random_sent) count = RANDOM_ITEMS - random_sent;
         for (k = 0; k < count; k++) begin
            send_pixel(random_pixel(), (k == 0 && fresh) || ($urandom_range(0, 63) == 0));
            random_sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------

   initial begin
      clock                  = 1'b0;
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = '0;
      csr_wdata              = '0;
      req_bus.valid          = 1'b0;
      req_bus.pixel_value    = '0;
      req_bus.start_of_frame = 1'b0;
      rsp_bus.ready          = 1'b0;

      cfg_shift_x    = '0;
      cfg_shift_y    = '0;
      cfg_width      = WIDTH_RESET;
      row_acc        = '0;
      col_pos        = 0;
      group_row      = 0;
      pixels_sent    = 0;
      bins_checked   = 0;
      csr_writes     = 0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      stall_left     = 0;
      gap_pct        = 12;
      stall_pct      = 12;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_saturation();
      test_range_clamps();
      test_width_cut();
      test_group_cut();
      test_wide_rows();
      test_random_frames();
      settle_block();

      $display("sent %0d pixel beats over %0d register writes, checked %0d binned beats",
               pixels_sent, csr_writes, bins_checked);
      $display("covered clamped factors and widths, saturation, width and group cuts");
      if (mismatch_count == 0) begin
         $display("PASS pixel_binning_saturating_core");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL pixel_binning_saturating_core");
      end
      $finish;
   end

endmodule

[pixel_binning_saturating_core.f]
+incdir+rtl
rtl/pbs_pkg.sv
rtl/pbs_req_if.sv
rtl/pbs_rsp_if.sv
rtl/pbs_line_store.sv
rtl/pixel_binning_saturating_core.sv
dv/tb_pixel_binning_saturating_core.sv
